// File: hdl/shd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shd_pkg;

    localparam int MAX_BINS_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int FIELD_W      = 6;
    localparam int LIM_W        = 8;
    localparam int LIMIT_MIN    = 3;
    localparam logic [FIELD_W-1:0] LIMIT_RESET = 6'd32;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int DIV_CNT_W    = 7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_LIM_CHK,
        ST_MS_LD,
        ST_MS_RD,
        ST_MS_CMP,
        ST_MG_RD0,
        ST_MG_LD0,
        ST_MG_RD1,
        ST_MG_LD1,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_MG_WR,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_EMPTY
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_RD_IDX,
        OP_SRCH_NEXT,
        OP_UPD,
        OP_INS_INIT,
        OP_RD_IDXM1,
        OP_INS_WR,
        OP_INS_NEW,
        OP_MS_INIT,
        OP_MS_LD,
        OP_MS_CMP,
        OP_RD_BEST,
        OP_LD_LO,
        OP_RD_BESTP1,
        OP_LD_HI,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MG_WR,
        OP_RD_IDXP1,
        OP_SH_WR,
        OP_SH_END,
        OP_DUMP_INIT,
        OP_DUMP_OUT,
        OP_EMIT_ADD,
        OP_EMIT_EMPTY
    } dp_op_t;

    typedef struct packed {
        logic idx_eq_n;
        logic idx_eq_pos;
        logic rd_lt_pt;
        logic rd_eq_pt;
        logic over_limit;
        logic ms_last;
        logic div_done;
        logic sh_end;
        logic dump_last;
        logic n_zero;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/shd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module shd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               cmd,
    input  wire shd_pkg::dp_status_t status,
    output shd_pkg::dp_op_t          op,
    output logic                    busy
);

    shd_pkg::state_t state_reg;
    shd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!cmd)
                        state_next = shd_pkg::ST_SRCH_RD;
                    else if (status.n_zero)
                        state_next = shd_pkg::ST_EMPTY;
                    else
                        state_next = shd_pkg::ST_DUMP_RD;
                end
            end
            shd_pkg::ST_SRCH_RD:
                state_next = status.idx_eq_n ? shd_pkg::ST_INS_RD : shd_pkg::ST_SRCH_CHK;
            shd_pkg::ST_SRCH_CHK:
            begin
                priority if (status.rd_lt_pt)
                    state_next = shd_pkg::ST_SRCH_RD;
                else if (status.rd_eq_pt)
                    state_next = shd_pkg::ST_LIM_CHK;
                else
                    state_next = shd_pkg::ST_INS_RD;
            end
            shd_pkg::ST_INS_RD:
                state_next = status.idx_eq_pos ? shd_pkg::ST_LIM_CHK : shd_pkg::ST_INS_WR;
            shd_pkg::ST_INS_WR:
                state_next = shd_pkg::ST_INS_RD;
            shd_pkg::ST_LIM_CHK:
                state_next = status.over_limit ? shd_pkg::ST_MS_LD : shd_pkg::ST_DONE;
            shd_pkg::ST_MS_LD:
                state_next = shd_pkg::ST_MS_RD;
            shd_pkg::ST_MS_RD:
                state_next = shd_pkg::ST_MS_CMP;
            shd_pkg::ST_MS_CMP:
                state_next = status.ms_last ? shd_pkg::ST_MG_RD0 : shd_pkg::ST_MS_RD;
            shd_pkg::ST_MG_RD0:
                state_next = shd_pkg::ST_MG_LD0;
            shd_pkg::ST_MG_LD0:
                state_next = shd_pkg::ST_MG_RD1;
            shd_pkg::ST_MG_RD1:
                state_next = shd_pkg::ST_MG_LD1;
            shd_pkg::ST_MG_LD1:
                state_next = shd_pkg::ST_MUL;
            shd_pkg::ST_MUL:
                state_next = shd_pkg::ST_DIV_INIT;
            shd_pkg::ST_DIV_INIT:
                state_next = shd_pkg::ST_DIV;
            shd_pkg::ST_DIV:
                state_next = status.div_done ? shd_pkg::ST_MG_WR : shd_pkg::ST_DIV;
            shd_pkg::ST_MG_WR:
                state_next = shd_pkg::ST_SH_RD;
            shd_pkg::ST_SH_RD:
                state_next = status.sh_end ? shd_pkg::ST_DONE : shd_pkg::ST_SH_WR;
            shd_pkg::ST_SH_WR:
                state_next = shd_pkg::ST_SH_RD;
            shd_pkg::ST_DONE:
                state_next = shd_pkg::ST_IDLE;
            shd_pkg::ST_DUMP_RD:
                state_next = shd_pkg::ST_DUMP_OUT;
            shd_pkg::ST_DUMP_OUT:
                state_next = status.dump_last ? shd_pkg::ST_IDLE : shd_pkg::ST_DUMP_RD;
            shd_pkg::ST_EMPTY:
                state_next = shd_pkg::ST_IDLE;
            default:
                state_next = shd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op   = shd_pkg::OP_NONE;
        busy = (state_reg != shd_pkg::ST_IDLE);
        unique case (state_reg)
            shd_pkg::ST_IDLE:
            begin
                if (start)
                    op = cmd ? shd_pkg::OP_DUMP_INIT : shd_pkg::OP_START;
            end
            shd_pkg::ST_SRCH_RD:
                op = status.idx_eq_n ? shd_pkg::OP_INS_INIT : shd_pkg::OP_RD_IDX;
            shd_pkg::ST_SRCH_CHK:
            begin
                priority if (status.rd_lt_pt)
                    op = shd_pkg::OP_SRCH_NEXT;
                else if (status.rd_eq_pt)
                    op = shd_pkg::OP_UPD;
                else
                    op = shd_pkg::OP_INS_INIT;
            end
            shd_pkg::ST_INS_RD:
                op = status.idx_eq_pos ? shd_pkg::OP_INS_NEW : shd_pkg::OP_RD_IDXM1;
            shd_pkg::ST_INS_WR:  op = shd_pkg::OP_INS_WR;
            shd_pkg::ST_LIM_CHK:
                op = status.over_limit ? shd_pkg::OP_MS_INIT : shd_pkg::OP_NONE;
            shd_pkg::ST_MS_LD:   op = shd_pkg::OP_MS_LD;
            shd_pkg::ST_MS_RD:   op = shd_pkg::OP_RD_IDX;
            shd_pkg::ST_MS_CMP:  op = shd_pkg::OP_MS_CMP;
            shd_pkg::ST_MG_RD0:  op = shd_pkg::OP_RD_BEST;
            shd_pkg::ST_MG_LD0:  op = shd_pkg::OP_LD_LO;
            shd_pkg::ST_MG_RD1:  op = shd_pkg::OP_RD_BESTP1;
            shd_pkg::ST_MG_LD1:  op = shd_pkg::OP_LD_HI;
            shd_pkg::ST_MUL:     op = shd_pkg::OP_MUL;
            shd_pkg::ST_DIV_INIT: op = shd_pkg::OP_DIV_INIT;
            shd_pkg::ST_DIV:     op = shd_pkg::OP_DIV_STEP;
            shd_pkg::ST_MG_WR:   op = shd_pkg::OP_MG_WR;
            shd_pkg::ST_SH_RD:
                op = status.sh_end ? shd_pkg::OP_SH_END : shd_pkg::OP_RD_IDXP1;
            shd_pkg::ST_SH_WR:   op = shd_pkg::OP_SH_WR;
            shd_pkg::ST_DONE:    op = shd_pkg::OP_EMIT_ADD;
            shd_pkg::ST_DUMP_RD: op = shd_pkg::OP_RD_IDX;
            shd_pkg::ST_DUMP_OUT: op = shd_pkg::OP_DUMP_OUT;
            shd_pkg::ST_EMPTY:   op = shd_pkg::OP_EMIT_EMPTY;
            default:             op = shd_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/shd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module shd_dp #(
    parameter int MAX_BINS = shd_pkg::MAX_BINS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire shd_pkg::dp_op_t              op,
    input  wire logic [shd_pkg::DATA_W-1:0]   point,
    input  wire logic [shd_pkg::DATA_W-1:0]   count,
    input  wire logic                         cfg_we,
    input  wire logic [shd_pkg::FIELD_W-1:0]  cfg_data,
    output shd_pkg::dp_status_t               status,
    output logic                              done,
    output logic [shd_pkg::DATA_W-1:0]        centroid,
    output logic [shd_pkg::DATA_W-1:0]        weight,
    output logic [shd_pkg::FIELD_W-1:0]       position,
    output logic [shd_pkg::FIELD_W-1:0]       active_count,
    output logic                              merged,
    output logic                              weight_saturated,
    output logic                              last
);

    localparam int DEPTH = MAX_BINS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BINS + 2);
    localparam int DW    = shd_pkg::DATA_W;
    localparam int PW    = shd_pkg::PROD_W;
    localparam int LW    = shd_pkg::LIM_W;
    localparam int FW    = shd_pkg::FIELD_W;
    localparam int QW    = shd_pkg::DIV_CNT_W;

    logic [DW-1:0] cent_mem [DEPTH];
    logic [DW-1:0] wgt_mem  [DEPTH];

    logic [DW-1:0] rd_cent_reg;
    logic [DW-1:0] rd_wgt_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_cent;
    logic [DW-1:0] wr_wgt;

    logic [FW-1:0] limit_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] best_reg, best_next;
    logic [DW-1:0] bestd_reg, bestd_next;
    logic          found_reg, found_next;
    logic [DW-1:0] pt_reg, pt_next;
    logic [DW-1:0] cnt_reg, cnt_next;
    logic          sat_reg, sat_next;
    logic          merged_reg, merged_next;
    logic [DW-1:0] prev_reg, prev_next;
    logic [DW-1:0] lo_reg, lo_next;
    logic [DW-1:0] hi_reg, hi_next;
    logic [DW-1:0] c0_reg, c0_next;
    logic [DW-1:0] c1_reg, c1_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [DW+1:0] rem_reg, rem_next;
    logic [DW:0]   sum_reg, sum_next;
    logic [QW-1:0] dcnt_reg, dcnt_next;

    logic          done_reg, done_next;
    logic [DW-1:0] ocent_reg, ocent_next;
    logic [DW-1:0] owgt_reg, owgt_next;
    logic [FW-1:0] opos_reg, opos_next;
    logic [FW-1:0] oact_reg, oact_next;
    logic          omrg_reg, omrg_next;
    logic          osat_reg, osat_next;
    logic          olast_reg, olast_next;

    logic [LW-1:0] lim;
    logic [DW:0]   upd_sum;
    logic [DW-1:0] pair_gap;
    logic [DW-1:0] span;
    logic [DW+1:0] rem_sh;
    logic [DW+1:0] rem_sub;
    logic [DW+1:0] mid;
    logic [DW-1:0] merge_val;
    logic [DW:0]   merge_sum;

    // Clamp the configured limit into the legal range.
    always_comb
    begin
        priority if (LW'(limit_reg) < LW'(shd_pkg::LIMIT_MIN))
            lim = LW'(shd_pkg::LIMIT_MIN);
        else if (LW'(limit_reg) > LW'(MAX_BINS))
            lim = LW'(MAX_BINS);
        else
            lim = LW'(limit_reg);
    end

    assign upd_sum   = {1'b0, rd_wgt_reg} + {1'b0, cnt_reg};
    assign pair_gap  = rd_cent_reg - prev_reg;
    // The pair is sorted, so the 32-bit difference is the exact unsigned span.
    assign span      = hi_reg - lo_reg;
    assign rem_sh    = {rem_reg[DW:0], quo_reg[PW-1]};
    assign rem_sub   = rem_sh - {1'b0, sum_reg};
    assign merge_sum = {1'b0, c0_reg} + {1'b0, c1_reg};

    // Weighted mean: low value plus the truncated offset, rounded toward zero.
    always_comb
    begin
        mid = {{2{lo_reg[DW-1]}}, lo_reg} + {2'b00, quo_reg[DW-1:0]};
        if ((rem_reg != '0) && mid[DW+1])
            mid = mid + (DW+2)'(1);
        merge_val = (sum_reg == '0) ? lo_reg : mid[DW-1:0];
    end

    always_comb
    begin
        status.idx_eq_n   = (idx_reg == n_reg);
        status.idx_eq_pos = (idx_reg == pos_reg);
        status.rd_lt_pt   = ($signed(rd_cent_reg) < $signed(pt_reg));
        status.rd_eq_pt   = (rd_cent_reg == pt_reg);
        status.over_limit = (LW'(n_reg) > lim);
        status.ms_last    = (idx_reg + CW'(2) == n_reg);
        status.div_done   = (dcnt_reg == QW'(1));
        status.sh_end     = (idx_reg + CW'(1) >= n_reg);
        status.dump_last  = (idx_reg + CW'(1) == n_reg);
        status.n_zero     = (n_reg == '0);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_cent = rd_cent_reg;
        wr_wgt  = rd_wgt_reg;

        n_next      = n_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        bestd_next  = bestd_reg;
        found_next  = found_reg;
        pt_next     = pt_reg;
        cnt_next    = cnt_reg;
        sat_next    = sat_reg;
        merged_next = merged_reg;
        prev_next   = prev_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        sum_next    = sum_reg;
        dcnt_next   = dcnt_reg;

        done_next  = 1'b0;
        ocent_next = '0;
        owgt_next  = '0;
        opos_next  = '0;
        oact_next  = FW'(n_reg);
        omrg_next  = 1'b0;
        osat_next  = 1'b0;
        olast_next = 1'b0;

        unique case (op)
            shd_pkg::OP_NONE:
            begin
            end
            shd_pkg::OP_START:
            begin
                pt_next     = point;
                cnt_next    = count;
                idx_next    = '0;
                sat_next    = 1'b0;
                merged_next = 1'b0;
            end
            shd_pkg::OP_RD_IDX:
                rd_en = 1'b1;
            shd_pkg::OP_SRCH_NEXT:
                idx_next = idx_reg + CW'(1);
            shd_pkg::OP_UPD:
            begin
                wr_en = 1'b1;
                if (upd_sum[DW])
                begin
                    wr_wgt   = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    wr_wgt = upd_sum[DW-1:0];
                end
            end
            shd_pkg::OP_INS_INIT:
            begin
                pos_next = idx_reg;
                idx_next = n_reg;
            end
            shd_pkg::OP_RD_IDXM1:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg - CW'(1));
            end
            shd_pkg::OP_INS_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            shd_pkg::OP_INS_NEW:
            begin
                wr_en   = 1'b1;
                wr_cent = pt_reg;
                wr_wgt  = cnt_reg;
                n_next  = n_reg + CW'(1);
            end
            shd_pkg::OP_MS_INIT:
            begin
                rd_en       = 1'b1;
                rd_addr     = AW'(1);
                idx_next    = CW'(2);
                found_next  = 1'b0;
                merged_next = 1'b1;
            end
            shd_pkg::OP_MS_LD:
                prev_next = rd_cent_reg;
            shd_pkg::OP_MS_CMP:
            begin
                if (!found_reg || (pair_gap < bestd_reg))
                begin
                    bestd_next = pair_gap;
                    best_next  = idx_reg - CW'(1);
                    found_next = 1'b1;
                end
                prev_next = rd_cent_reg;
                idx_next  = idx_reg + CW'(1);
            end
            shd_pkg::OP_RD_BEST:
            begin
                rd_en   = 1'b1;
                rd_addr = best_reg[AW-1:0];
            end
            shd_pkg::OP_LD_LO:
            begin
                lo_next = rd_cent_reg;
                c0_next = rd_wgt_reg;
            end
            shd_pkg::OP_RD_BESTP1:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(best_reg + CW'(1));
            end
            shd_pkg::OP_LD_HI:
            begin
                hi_next = rd_cent_reg;
                c1_next = rd_wgt_reg;
            end
            shd_pkg::OP_MUL:
            begin
                quo_next = {{DW{1'b0}}, span} * {{DW{1'b0}}, c1_reg};
                sum_next = merge_sum;
            end
            shd_pkg::OP_DIV_INIT:
            begin
                rem_next  = '0;
                dcnt_next = QW'(PW);
            end
            shd_pkg::OP_DIV_STEP:
            begin
                if (!rem_sub[DW+1])
                begin
                    rem_next = rem_sub;
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - QW'(1);
            end
            shd_pkg::OP_MG_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = best_reg[AW-1:0];
                wr_cent = merge_val;
                if (merge_sum[DW])
                begin
                    wr_wgt   = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    wr_wgt = merge_sum[DW-1:0];
                end
                idx_next = best_reg + CW'(1);
            end
            shd_pkg::OP_RD_IDXP1:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            shd_pkg::OP_SH_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + CW'(1);
            end
            shd_pkg::OP_SH_END:
                n_next = n_reg - CW'(1);
            shd_pkg::OP_DUMP_INIT:
                idx_next = '0;
            shd_pkg::OP_DUMP_OUT:
            begin
                done_next  = 1'b1;
                ocent_next = rd_cent_reg;
                owgt_next  = rd_wgt_reg;
                opos_next  = FW'(idx_reg);
                olast_next = status.dump_last;
                idx_next   = idx_reg + CW'(1);
            end
            shd_pkg::OP_EMIT_ADD:
            begin
                done_next  = 1'b1;
                omrg_next  = merged_reg;
                osat_next  = sat_reg;
                olast_next = 1'b1;
            end
            shd_pkg::OP_EMIT_EMPTY:
            begin
                done_next  = 1'b1;
                olast_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cent_mem[wr_addr] <= wr_cent;
            wgt_mem[wr_addr]  <= wr_wgt;
        end
        if (rd_en)
        begin
            rd_cent_reg <= cent_mem[rd_addr];
            rd_wgt_reg  <= wgt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= shd_pkg::LIMIT_RESET;
            n_reg     <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            sat_reg   <= 1'b0;
            merged_reg <= 1'b0;
            dcnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            best_reg   <= best_next;
            found_reg  <= found_next;
            sat_reg    <= sat_next;
            merged_reg <= merged_next;
            dcnt_reg   <= dcnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bestd_reg <= bestd_next;
        pt_reg    <= pt_next;
        cnt_reg   <= cnt_next;
        prev_reg  <= prev_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        sum_reg   <= sum_next;
        ocent_reg <= ocent_next;
        owgt_reg  <= owgt_next;
        opos_reg  <= opos_next;
        oact_reg  <= oact_next;
        omrg_reg  <= omrg_next;
        osat_reg  <= osat_next;
        olast_reg <= olast_next;
    end

    assign done             = done_reg;
    assign centroid         = ocent_reg;
    assign weight           = owgt_reg;
    assign position         = opos_reg;
    assign active_count     = oact_reg;
    assign merged           = omrg_reg;
    assign weight_saturated = osat_reg;
    assign last             = olast_reg;

endmodule

`default_nettype wire

// File: hdl/streaming_histogram_digest.sv
// Channel   Handshake           Ports
// input     start & !busy       cmd, point, count
// result    done (one cycle)    centroid, weight, position, active_count,
//                               merged, weight_saturated, last
// config    cfg_we              cfg_data (bin limit)
//
// An add scans entries and then shifts entries up through the centroid memory.
// A merge adds a search over the candidate pairs, the 64-step restoring divider
// and a shift of entries down.
// A dump reads each centroid in turn; each beat shows in the cycle after its state.
// Reset clears the count of held centroids; the memories need no clearing.
// The receiver cannot stall: each result beat shows on done for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module streaming_histogram_digest #(
    parameter int MAX_BINS = shd_pkg::MAX_BINS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cmd,
    input  wire logic [shd_pkg::DATA_W-1:0]   point,
    input  wire logic [shd_pkg::DATA_W-1:0]   count,
    input  wire logic                         cfg_we,
    input  wire logic [shd_pkg::FIELD_W-1:0]  cfg_data,
    output logic                              done,
    output logic [shd_pkg::DATA_W-1:0]        centroid,
    output logic [shd_pkg::DATA_W-1:0]        weight,
    output logic [shd_pkg::FIELD_W-1:0]       position,
    output logic [shd_pkg::FIELD_W-1:0]       active_count,
    output logic                              merged,
    output logic                              weight_saturated,
    output logic                              last
);

    shd_pkg::dp_op_t     op;
    shd_pkg::dp_status_t status;

    shd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    shd_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .point            (point),
        .count            (count),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .status           (status),
        .done             (done),
        .centroid         (centroid),
        .weight           (weight),
        .position         (position),
        .active_count     (active_count),
        .merged           (merged),
        .weight_saturated (weight_saturated),
        .last             (last)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef enum {K_ADD, K_DUMP, K_CFG, K_DRAIN} beat_kind_t;

    typedef struct {
        beat_kind_t  kind;
        logic [31:0] point;
        logic [31:0] count;
        logic [5:0]  limit;
    } digest_op_t;

    typedef struct {
        logic [31:0] centroid;
        logic [31:0] weight;
        logic [5:0]  position;
        logic [5:0]  active_count;
        logic        merged;
        logic        weight_saturated;
        logic        last;
    } digest_result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic cmd = 0;
    logic [31:0] point = 0;
    logic [31:0] count = 0;
    logic cfg_we = 0;
    logic [5:0] cfg_data = 0;
    logic done;
    logic [31:0] centroid;
    logic [31:0] weight;
    logic [5:0] position;
    logic [5:0] active_count;
    logic merged;
    logic weight_saturated;
    logic last;

    streaming_histogram_digest dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .point(point), .count(count), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .centroid(centroid), .weight(weight), .position(position),
        .active_count(active_count), .merged(merged),
        .weight_saturated(weight_saturated), .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Shadow copy of the digest contents.
    longint      bin_value [0:32];
    logic [31:0] bin_mass [0:32];
    int          bins_held = 0;
    logic [5:0]  limit_reg = 6'd32;

    digest_op_t     pending_ops[$];
    digest_result_t expected_results[$];
    int             error_count = 0;

    function automatic int limit_in_force();
        int lim;
        lim = limit_reg;
        if (lim < shd_pkg::LIMIT_MIN) lim = shd_pkg::LIMIT_MIN;
        if (lim > 32) lim = 32;
        return lim;
    endfunction

    function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b, ref logic sat);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[32])
        begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic void merge_nearest(ref logic sat);
        int best;
        logic [63:0] best_gap;
        logic [63:0] gap;
        longint lo;
        longint hi;
        logic [63:0] num;
        logic [63:0] total;
        logic [63:0] q;
        logic [63:0] r;
        longint m;
        best = 1;
        best_gap = '1;
        // The outermost pairs are never candidates.
        for (int k = 1; k + 2 < bins_held; k++)
        begin
            gap = bin_value[k+1] - bin_value[k];
            if (k == 1 || gap < best_gap)
            begin
                best_gap = gap;
                best = k;
            end
        end
        lo = bin_value[best];
        hi = bin_value[best+1];
        total = {32'b0, bin_mass[best]} + {32'b0, bin_mass[best+1]};
        m = lo;
        if (total != 0)
        begin
            num = (hi - lo) * {32'b0, bin_mass[best+1]};
            q = num / total;
            r = num % total;
            m = lo + longint'(q);
            if (r != 0 && m < 0) m = m + 1;
        end
        bin_value[best] = m;
        bin_mass[best] = clamp_sum(bin_mass[best], bin_mass[best+1], sat);
        for (int j = best + 1; j + 1 < bins_held; j++)
        begin
            bin_value[j] = bin_value[j+1];
            bin_mass[j] = bin_mass[j+1];
        end
        bins_held--;
    endfunction

    function automatic void predict_digest(digest_op_t op);
        digest_result_t res;
        longint pt;
        int pos;
        logic sat;
        logic mg;
        if (op.kind == K_DUMP)
        begin
            if (bins_held == 0)
            begin
                res = '{default: '0};
                res.last = 1'b1;
                expected_results.push_back(res);
                return;
            end
            for (int i = 0; i < bins_held; i++)
            begin
                res.centroid = bin_value[i][31:0];
                res.weight = bin_mass[i];
                res.position = i;
                res.active_count = bins_held;
                res.merged = 1'b0;
                res.weight_saturated = 1'b0;
                res.last = (i + 1 == bins_held);
                expected_results.push_back(res);
            end
            return;
        end
        pt = longint'($signed(op.point));
        sat = 1'b0;
        mg = 1'b0;
        pos = 0;
        while (pos < bins_held && bin_value[pos] < pt) pos++;
        if (pos < bins_held && bin_value[pos] == pt)
            bin_mass[pos] = clamp_sum(bin_mass[pos], op.count, sat);
        else
        begin
            for (int j = bins_held; j > pos; j--)
            begin
                bin_value[j] = bin_value[j-1];
                bin_mass[j] = bin_mass[j-1];
            end
            bin_value[pos] = pt;
            bin_mass[pos] = op.count;
            bins_held++;
        end
        if (bins_held > limit_in_force())
        begin
            merge_nearest(sat);
            mg = 1'b1;
        end
        res = '{default: '0};
        res.active_count = bins_held;
        res.merged = mg;
        res.weight_saturated = sat;
        res.last = 1'b1;
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Driver: beats leave the queue in order; limit writes and pauses wait for an
    // idle block with nothing outstanding.
    digest_op_t cur_op;
    int  gap_left = 0;
    int  settle = 0;
    logic next_start;
    logic next_we;

    always @(posedge clk)
    begin
        next_start = start;
        next_we = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_digest(cur_op);
                next_start = 1'b0;
                gap_left = pick_gap();
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ops.size() > 0)
                begin
                    if (pending_ops[0].kind == K_ADD || pending_ops[0].kind == K_DUMP)
                    begin
                        cur_op = pending_ops.pop_front();
                        cmd <= (cur_op.kind == K_DUMP);
                        point <= cur_op.point;
                        count <= cur_op.count;
                        next_start = 1'b1;
                    end
                    else if (expected_results.size() == 0 && !busy && !start)
                    begin
                        if (settle < 30)
                            settle++;
                        else
                        begin
                            settle = 0;
                            cur_op = pending_ops.pop_front();
                            if (cur_op.kind == K_CFG)
                            begin
                                cfg_data <= cur_op.limit;
                                limit_reg = cur_op.limit;
                                next_we = 1'b1;
                            end
                        end
                    end
                    else
                        settle = 0;
                end
            end
        end
        start <= next_start;
        cfg_we <= next_we;
    end

    // Monitor and watchdog.
    digest_result_t want;
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (centroid !== want.centroid)
                        report_mismatch("centroid", centroid, want.centroid);
                    if (weight !== want.weight)
                        report_mismatch("weight", weight, want.weight);
                    if (position !== want.position)
                        report_mismatch("position", position, want.position);
                    if (active_count !== want.active_count)
                        report_mismatch("active_count", active_count, want.active_count);
                    if (merged !== want.merged)
                        report_mismatch("merged", merged, want.merged);
                    if (weight_saturated !== want.weight_saturated)
                        report_mismatch("weight_saturated", weight_saturated,
                                        want.weight_saturated);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (done || (start && !busy) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_op(beat_kind_t kind, logic [31:0] p, logic [31:0] c, logic [5:0] lim);
        digest_op_t op;
        op.kind = kind;
        op.point = p;
        op.count = c;
        op.limit = lim;
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] random_point(ref logic [31:0] pool[$]);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return pool[$urandom_range(0, pool.size() - 1)];
        if (r < 80) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        return $urandom();
    endfunction

    function automatic logic [31:0] random_count();
        int r;
        logic [31:0] c;
        r = $urandom_range(0, 99);
        if (r < 60) c = $urandom_range(1, 32'h0003_0000);
        else if (r < 80) c = $urandom();
        else c = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
        return (c == 0) ? 32'd1 : c;
    endfunction

    logic [31:0] value_pool[$];
    logic [5:0]  phase_limits[$];

    initial
    begin
        // Directed part: empty dump, limit clamping, field extremes, saturation.
        queue_op(K_DUMP, 32'h0, 32'h0, 6'd0);
        queue_op(K_CFG, 32'h0, 32'h0, 6'd0);
        queue_op(K_ADD, 32'h8000_0000, 32'h0000_0001, 6'd0);
        queue_op(K_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        queue_op(K_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        queue_op(K_ADD, 32'h0000_0000, 32'h0001_0000, 6'd0);
        queue_op(K_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        queue_op(K_ADD, 32'h0000_0001, 32'h8000_0000, 6'd0);
        queue_op(K_ADD, 32'hFFFF_0000, 32'h0000_0003, 6'd0);
        queue_op(K_DUMP, 32'h0, 32'h0, 6'd0);
        queue_op(K_CFG, 32'h0, 32'h0, 6'd63);
        queue_op(K_ADD, 32'h0001_0000, 32'h0000_0002, 6'd0);
        queue_op(K_ADD, 32'h0002_8000, 32'hFFFF_FFFE, 6'd0);
        queue_op(K_DUMP, 32'h0, 32'h0, 6'd0);
        queue_op(K_CFG, 32'h0, 32'h0, 6'd4);
        queue_op(K_ADD, 32'h0001_0001, 32'hFFFF_FFFF, 6'd0);
        queue_op(K_ADD, 32'h0001_0002, 32'hFFFF_FFFF, 6'd0);
        queue_op(K_DUMP, 32'h0, 32'h0, 6'd0);
        queue_op(K_DRAIN, 32'h0, 32'h0, 6'd0);

        // Random phases, each under its own limit, each ending in a dump.
        phase_limits = '{6'd3, 6'd32, 6'd5, 6'd63, 6'd8, 6'd1, 6'd20};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < phase_limits.size())
                queue_op(K_CFG, 32'h0, 32'h0, phase_limits[ph]);
            else
                queue_op(K_CFG, 32'h0, 32'h0, $urandom_range(0, 63));
            value_pool.delete();
            for (int i = 0; i < 10; i++)
                value_pool.push_back($urandom());
            for (int i = 0; i < 25; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_op(K_DUMP, $urandom(), $urandom(), 6'd0);
                else
                    queue_op(K_ADD, random_point(value_pool), random_count(), 6'd0);
            end
            queue_op(K_DUMP, 32'h0, 32'h0, 6'd0);
            if (ph % 2 == 0)
                queue_op(K_DRAIN, 32'h0, 32'h0, 6'd0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start || expected_results.size() > 0 || busy)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
